// ===== rtl/cle_pkg.sv =====
// Shared types, character codes and echo tables for the console line editor.
package cle_pkg;

  localparam int POS_W  = 5;
  localparam int CHAR_W = 8;
  localparam int KIND_W = 2;

  // Configuration register index (byte address bit 2).
  localparam logic REG_MAX_CHARS = 1'b0;
  localparam logic [POS_W-1:0] MAX_CHARS_RESET = 5'd31;

  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_DEL   = 8'h7F;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_ETX   = 8'h03;
  localparam logic [CHAR_W-1:0] CH_BEL   = 8'h07;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_CARET = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_UPPER_C = 8'h43;

  typedef enum logic [KIND_W-1:0] {
    KIND_ECHO   = 2'd0,
    KIND_LINE   = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_CANCEL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    CMD_CR,
    CMD_ETX,
    CMD_ERASE,
    CMD_BELL,
    CMD_STORE
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ECHO,
    S_LREQ,
    S_LDAT,
    S_DONE
  } state_t;

  // Echo byte for a given step of a command's echo sequence.
  function automatic logic [CHAR_W-1:0] echo_byte(cmd_t cmd, logic [CHAR_W-1:0] ch,
                                                  logic [1:0] step);
    logic [CHAR_W-1:0] b;
    b = ch;
    unique case (cmd)
      CMD_CR:    b = (step == 2'd0) ? CH_CR : CH_LF;
      CMD_ETX: begin
        case (step)
          2'd0:    b = CH_CARET;
          2'd1:    b = CH_UPPER_C;
          2'd2:    b = CH_CR;
          default: b = CH_LF;
        endcase
      end
      CMD_ERASE: b = (step == 2'd1) ? CH_SPACE : CH_BS;
      CMD_BELL:  b = CH_BEL;
      default:   b = ch;
    endcase
    return b;
  endfunction

  // Index of the final echo byte of a command.
  function automatic logic [1:0] echo_last_step(cmd_t cmd);
    logic [1:0] s;
    s = 2'd0;
    unique case (cmd)
      CMD_CR:    s = 2'd1;
      CMD_ETX:   s = 2'd3;
      CMD_ERASE: s = 2'd2;
      default:   s = 2'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/cle_stream_if.sv =====
// Valid/ready stream interfaces for received bytes and editor results.
interface cle_in_if;
  logic                      valid;
  logic                      ready;
  logic [cle_pkg::CHAR_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cle_out_if;
  logic                       valid;
  logic                       ready;
  logic [cle_pkg::KIND_W-1:0] kind;
  logic [cle_pkg::CHAR_W-1:0] value;
  logic [cle_pkg::POS_W-1:0]  length;
  logic                       last;

  modport source (output valid, output kind, output value, output length, output last,
                  input ready);
  modport sink   (input valid, input kind, input value, input length, input last,
                  output ready);
endinterface

// ===== rtl/console_line_editor.sv =====
// Sequencing: an accepted byte moves the editor to the echo state, which loads each echo or
// status item into the output register in turn, holding while the output is full; a carriage
// return then reads each stored character through a read issue state and a data state on the
// line store's single port. One byte at a time: the next byte is taken once the last result is registered.
// Reset (rst, synchronous): position 0, max_chars 31, output empty; the line store is not
// cleared, since only written entries below the position are ever read.
module console_line_editor #(
  parameter int LINE_DEPTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  cle_in_if.sink           rx,
  cle_out_if.source        tx
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int ROOM_CAP_I = (LINE_DEPTH >= 31) ? 31 : LINE_DEPTH;
  localparam logic [cle_pkg::POS_W-1:0] ROOM_CAP = cle_pkg::POS_W'(ROOM_CAP_I);

  cle_pkg::state_t state, state_next;
  cle_pkg::cmd_t   cmd, cmd_next, cmd_dec;

  logic [cle_pkg::CHAR_W-1:0] ch, ch_next;
  logic [1:0]                 step, step_next;
  logic [cle_pkg::POS_W-1:0]  rd_idx, rd_idx_next;
  logic [cle_pkg::POS_W-1:0]  line_len, line_len_next;
  logic [cle_pkg::POS_W-1:0]  pos, pos_next;
  logic [cle_pkg::POS_W-1:0]  max_chars;
  logic [cle_pkg::POS_W-1:0]  room;

  logic                       out_valid;
  cle_pkg::kind_t             out_kind;
  logic [cle_pkg::CHAR_W-1:0] out_value;
  logic [cle_pkg::POS_W-1:0]  out_length;
  logic                       out_last;

  logic                       emit, load, accept, cfg_write;
  cle_pkg::kind_t             e_kind;
  logic [cle_pkg::CHAR_W-1:0] e_value;
  logic [cle_pkg::POS_W-1:0]  e_length;
  logic                       e_last;

  logic                       ram_we;
  logic [AW-1:0]              ram_addr;
  logic [cle_pkg::CHAR_W-1:0] ram_rdata;

  // Configuration port.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == cle_pkg::REG_MAX_CHARS) ? {27'd0, max_chars} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_chars <= cle_pkg::MAX_CHARS_RESET;
    end else if (cfg_write && paddr[2] == cle_pkg::REG_MAX_CHARS) begin
      max_chars <= pwdata[cle_pkg::POS_W-1:0];
    end
  end

  assign room = (max_chars > ROOM_CAP) ? ROOM_CAP : max_chars;

  assign rx.ready = (state == cle_pkg::S_IDLE);
  assign accept   = rx.valid && rx.ready;

  // Classify the incoming byte against the current line.
  always_comb begin
    if (rx.rx_byte == cle_pkg::CH_CR) begin
      cmd_dec = cle_pkg::CMD_CR;
    end else if (rx.rx_byte == cle_pkg::CH_ETX) begin
      cmd_dec = cle_pkg::CMD_ETX;
    end else if (rx.rx_byte == cle_pkg::CH_BS || rx.rx_byte == cle_pkg::CH_DEL) begin
      cmd_dec = (pos == '0) ? cle_pkg::CMD_BELL : cle_pkg::CMD_ERASE;
    end else if (pos >= room) begin
      cmd_dec = cle_pkg::CMD_BELL;
    end else begin
      cmd_dec = cle_pkg::CMD_STORE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cle_pkg::S_IDLE;
      pos   <= '0;
    end else begin
      state <= state_next;
      pos   <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd      <= cmd_next;
    ch       <= ch_next;
    step     <= step_next;
    rd_idx   <= rd_idx_next;
    line_len <= line_len_next;
  end

  always_comb begin
    state_next    = state;
    cmd_next      = cmd;
    ch_next       = ch;
    step_next     = step;
    rd_idx_next   = rd_idx;
    line_len_next = line_len;
    pos_next      = pos;
    emit          = 1'b0;
    e_kind        = cle_pkg::KIND_ECHO;
    e_value       = '0;
    e_length      = '0;
    e_last        = 1'b0;
    ram_we        = 1'b0;
    ram_addr      = AW'(rd_idx);
    load          = 1'b0;

    unique case (state)
      cle_pkg::S_IDLE: begin
        if (accept) begin
          state_next  = cle_pkg::S_ECHO;
          cmd_next    = cmd_dec;
          ch_next     = rx.rx_byte;
          step_next   = 2'd0;
          rd_idx_next = '0;
          unique case (cmd_dec)
            cle_pkg::CMD_CR: begin
              line_len_next = pos;
              pos_next      = '0;
            end
            cle_pkg::CMD_ETX:   pos_next = '0;
            cle_pkg::CMD_ERASE: pos_next = pos - 5'd1;
            cle_pkg::CMD_STORE: begin
              ram_we   = 1'b1;
              ram_addr = AW'(pos);
              pos_next = pos + 5'd1;
            end
            default: pos_next = pos;
          endcase
        end
      end
      cle_pkg::S_ECHO: begin
        emit    = 1'b1;
        e_value = cle_pkg::echo_byte(cmd, ch, step);
        e_last  = (step == cle_pkg::echo_last_step(cmd)) &&
                  cmd != cle_pkg::CMD_CR && cmd != cle_pkg::CMD_ETX;
        load    = !out_valid || tx.ready;
        if (load) begin
          if (step == cle_pkg::echo_last_step(cmd)) begin
            if (cmd == cle_pkg::CMD_CR) begin
              state_next = (line_len == '0) ? cle_pkg::S_DONE : cle_pkg::S_LREQ;
            end else if (cmd == cle_pkg::CMD_ETX) begin
              state_next = cle_pkg::S_DONE;
            end else begin
              state_next = cle_pkg::S_IDLE;
            end
          end else begin
            step_next = step + 2'd1;
          end
        end
      end
      cle_pkg::S_LREQ: begin
        state_next = cle_pkg::S_LDAT;
      end
      cle_pkg::S_LDAT: begin
        // Address is held at rd_idx, so the registered read data stays valid while stalled.
        emit    = 1'b1;
        e_kind  = cle_pkg::KIND_LINE;
        e_value = ram_rdata;
        load    = !out_valid || tx.ready;
        if (load) begin
          rd_idx_next = rd_idx + 5'd1;
          state_next  = (rd_idx + 5'd1 == line_len) ? cle_pkg::S_DONE : cle_pkg::S_LREQ;
        end
      end
      cle_pkg::S_DONE: begin
        emit     = 1'b1;
        e_kind   = (cmd == cle_pkg::CMD_CR) ? cle_pkg::KIND_DONE : cle_pkg::KIND_CANCEL;
        e_length = (cmd == cle_pkg::CMD_CR) ? line_len : '0;
        e_last   = 1'b1;
        load     = !out_valid || tx.ready;
        if (load) begin
          state_next = cle_pkg::S_IDLE;
        end
      end
      default: state_next = cle_pkg::S_IDLE;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (tx.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_kind   <= e_kind;
      out_value  <= e_value;
      out_length <= e_length;
      out_last   <= e_last;
    end
  end

  assign tx.valid  = out_valid;
  assign tx.kind   = out_kind;
  assign tx.value  = out_value;
  assign tx.length = out_length;
  assign tx.last   = out_last;

  cle_ram #(
    .WIDTH (cle_pkg::CHAR_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ch_next),
    .rdata (ram_rdata)
  );

`ifndef SYNTHESIS
  a_pos_cap: assert property (@(posedge clk) disable iff (rst) pos <= ROOM_CAP)
    else $error("line position beyond line capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> state != cle_pkg::S_IDLE)
    else $error("editor idle right after taking a byte");

  a_read_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == cle_pkg::S_LDAT || state == cle_pkg::S_LREQ) |-> rd_idx < line_len)
    else $error("line readout beyond line length");

  a_last_ends_byte: assert property (@(posedge clk) disable iff (rst)
    (load && e_last) |=> state == cle_pkg::S_IDLE)
    else $error("final result loaded but sequencer still busy");
`endif

endmodule

// ===== rtl/cle_ram.sv =====
// Generic single-port RAM with registered read data.
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== dv/tb_console_line_editor.sv =====
// Self-checking testbench for the console line editor: received bytes in, echo and line items out.
`timescale 1ns / 1ps
module tb_console_line_editor;

  localparam int DEPTH = 32;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 140;
  localparam int PHASE_ITEMS = 30;
  localparam logic [2:0] ADDR_MAX_CHARS = {cle_pkg::REG_MAX_CHARS, 2'b00};

  typedef struct packed {
    cle_pkg::kind_t             kind;
    logic [cle_pkg::CHAR_W-1:0] value;
    logic [cle_pkg::POS_W-1:0]  length;
    logic                       last;
  } editor_result_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cle_in_if  rx ();
  cle_out_if tx ();

  console_line_editor #(.LINE_DEPTH(DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rx      (rx),
    .tx      (tx)
  );

  logic [cle_pkg::CHAR_W-1:0] rx_byte_q[$];
  editor_result_t             editor_out_q[$];

  // Shadow copy of the editor's line state and its room setting.
  logic [cle_pkg::CHAR_W-1:0] shadow_line [DEPTH];
  int unsigned                shadow_pos;
  int unsigned                shadow_max;

  int   queued_cnt;
  int   accepted_cnt;
  int   error_cnt;
  int   cycle_cnt;
  int   idle_pct;
  logic rx_taken;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_cnt++;
  endtask

  function automatic void push_result(cle_pkg::kind_t k, logic [cle_pkg::CHAR_W-1:0] v,
                                      logic [cle_pkg::POS_W-1:0] len);
    editor_result_t r;
    r.kind   = k;
    r.value  = v;
    r.length = len;
    r.last   = 1'b0;
    editor_out_q.push_back(r);
  endfunction

  // Works out the burst of results that one received byte causes.
  function automatic void apply_rx_byte(logic [cle_pkg::CHAR_W-1:0] c);
    editor_result_t tail;
    int unsigned    room;
    room = (shadow_max < DEPTH) ? shadow_max : DEPTH;
    if (c == cle_pkg::CH_CR) begin
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, '0);
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, '0);
      for (int i = 0; i < shadow_pos; i++)
        push_result(cle_pkg::KIND_LINE, shadow_line[i], '0);
      push_result(cle_pkg::KIND_DONE, '0, cle_pkg::POS_W'(shadow_pos));
      shadow_pos = 0;
    end else if (c == cle_pkg::CH_ETX) begin
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_CARET, '0);
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_UPPER_C, '0);
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_CR, '0);
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_LF, '0);
      push_result(cle_pkg::KIND_CANCEL, '0, '0);
      shadow_pos = 0;
    end else if (c == cle_pkg::CH_BS || c == cle_pkg::CH_DEL) begin
      if (shadow_pos == 0) begin
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BEL, '0);
      end else begin
        shadow_pos--;
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0);
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_SPACE, '0);
        push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BS, '0);
      end
    end else if (shadow_pos >= room) begin
      push_result(cle_pkg::KIND_ECHO, cle_pkg::CH_BEL, '0);
    end else begin
      shadow_line[shadow_pos] = c;
      shadow_pos++;
      push_result(cle_pkg::KIND_ECHO, c, '0);
    end
    tail = editor_out_q.pop_back();
    tail.last = 1'b1;
    editor_out_q.push_back(tail);
  endfunction

  function automatic void queue_byte(logic [cle_pkg::CHAR_W-1:0] c);
    rx_byte_q.push_back(c);
    queued_cnt++;
  endfunction

  // Mostly printable text with a few erases and stray bytes, usually closed by CR or Ctrl-C.
  function automatic void queue_random_line();
    int unsigned len;
    int          pick;
    len = $urandom_range(shadow_max + 3, 0);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (pick < 78) begin
        queue_byte(8'($urandom_range(8'h7E, 8'h20)));
      end else if (pick < 86) begin
        queue_byte($urandom_range(1) ? cle_pkg::CH_BS : cle_pkg::CH_DEL);
      end else begin
        queue_byte(8'($urandom_range(255)));
      end
    end
    pick = $urandom_range(99);
    if (pick < 85) begin
      queue_byte(cle_pkg::CH_CR);
    end else if (pick < 95) begin
      queue_byte(cle_pkg::CH_ETX);
    end
  endfunction

  task automatic write_max_chars(input logic [cle_pkg::POS_W-1:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_CHARS;
    pwdata  <= 32'(val);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_max = val;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[cle_pkg::POS_W-1:0] !== val)
      report_mismatch($sformatf("max_chars reads %0d, wrote %0d",
                                prdata[cle_pkg::POS_W-1:0], val));
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the sender back until every queued byte is taken and every result has come.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (accepted_cnt != queued_cnt || editor_out_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Driver: offers the next pending byte once the previous transaction has completed.
  always @(negedge clk) begin
    if (rst) begin
      rx.valid <= 1'b0;
    end else if (!rx.valid || rx_taken) begin
      if (rx_byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
        rx.valid   <= 1'b1;
        rx.rx_byte <= rx_byte_q.pop_front();
      end else begin
        rx.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    tx.ready <= ($urandom_range(99) >= idle_pct);
  end

  // Monitor: predicts on each accepted byte and checks each accepted result in order.
  always @(posedge clk) begin
    editor_result_t want;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL console_line_editor");
      $finish;
    end else if (rst) begin
      rx_taken <= 1'b0;
    end else begin
      rx_taken <= rx.valid && rx.ready;
      if (rx.valid && rx.ready) begin
        apply_rx_byte(rx.rx_byte);
        accepted_cnt++;
      end
      if (tx.valid && tx.ready) begin
        if (editor_out_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result kind %0d value %02h length %0d last %0b",
                                    tx.kind, tx.value, tx.length, tx.last));
        end else begin
          want = editor_out_q.pop_front();
          if (tx.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, expected %0d", tx.kind, want.kind));
          if (tx.value !== want.value)
            report_mismatch($sformatf("value %02h, expected %02h", tx.value, want.value));
          if (tx.length !== want.length)
            report_mismatch($sformatf("length %0d, expected %0d", tx.length, want.length));
          if (tx.last !== want.last)
            report_mismatch($sformatf("last %0b, expected %0b", tx.last, want.last));
        end
      end
    end
  end

  initial begin
    int unsigned phase_cfg [6];
    int          phase_idx;
    int          random_start;
    int          phase_end;

    phase_cfg  = '{31, 0, 5, 1, 17, 31};
    rst        = 1'b1;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    rx.valid   = 1'b0;
    rx.rx_byte = '0;
    tx.ready   = 1'b0;
    idle_pct   = 16;
    shadow_pos = 0;
    shadow_max = cle_pkg::MAX_CHARS_RESET;
    queued_cnt = 0;
    accepted_cnt = 0;
    error_cnt  = 0;
    cycle_cnt  = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset room: store extremes and ESC, erase, close lines, erase and bell on an empty line.
    queue_byte(8'h61);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h1B);
    queue_byte(cle_pkg::CH_BS);
    queue_byte(cle_pkg::CH_DEL);
    queue_byte(cle_pkg::CH_CR);
    queue_byte(cle_pkg::CH_BS);
    queue_byte(cle_pkg::CH_DEL);
    queue_byte(cle_pkg::CH_CR);
    queue_byte(cle_pkg::CH_ETX);
    wait_drained();

    // No room at all: every storable byte rings the bell.
    write_max_chars(5'd0);
    queue_byte(8'h41);
    queue_byte(cle_pkg::CH_CR);
    wait_drained();

    // Line fills up and the third byte is refused.
    write_max_chars(5'd2);
    queue_byte(8'h31);
    queue_byte(8'h32);
    queue_byte(8'h33);
    queue_byte(cle_pkg::CH_CR);
    wait_drained();

    // Room lowered below the current position keeps the line until erased below it.
    write_max_chars(5'd31);
    queue_byte(8'h78);
    queue_byte(8'h79);
    queue_byte(8'h7A);
    wait_drained();
    write_max_chars(5'd1);
    queue_byte(8'h21);
    queue_byte(cle_pkg::CH_BS);
    queue_byte(cle_pkg::CH_BS);
    queue_byte(cle_pkg::CH_DEL);
    queue_byte(8'h23);
    queue_byte(cle_pkg::CH_CR);
    wait_drained();

    random_start = queued_cnt;
    phase_idx = 0;
    while (queued_cnt - random_start < RANDOM_ITEMS) begin
      write_max_chars(5'(phase_idx < 6 ? phase_cfg[phase_idx] : $urandom_range(31)));
      // The first random phase runs with no idling on either side.
      idle_pct = (phase_idx == 0) ? 0 : 16;
      phase_end = queued_cnt + PHASE_ITEMS;
      while (queued_cnt < phase_end) queue_random_line();
      wait_drained();
      phase_idx++;
    end

    if (error_cnt == 0) begin
      $display("PASS console_line_editor");
    end else begin
      $display("FAIL console_line_editor");
    end
    $finish;
  end

endmodule
